// ----- design/evhr_pkg.sv -----
// shared types, constants and sizes for the event history ring
package evhr_pkg;

    // ring geometry (depth is a power of two, slots wrap by truncation)
    localparam int LOG_DEPTH    = 256;
    localparam int PLAYER_COUNT = 8;
    localparam int PTR_W        = $clog2(LOG_DEPTH);
    localparam int CNT_W        = PTR_W + 1;

    // field widths
    localparam int ACTION_W = 3;
    localparam int PLAYER_W = 3;
    localparam int SOURCE_W = 8;
    localparam int KIND_W   = 8;
    localparam int AMOUNT_W = 16;
    localparam int TIME_W   = 32;
    localparam int POS_W    = 8;
    localparam int TOTAL_W  = CNT_W;

    localparam int IN_DATA_W   = PLAYER_W + SOURCE_W + KIND_W + AMOUNT_W + TIME_W + POS_W;
    localparam int IN_TDATA_W  = ((IN_DATA_W + 7) / 8) * 8;
    localparam int IN_PAD_W    = IN_TDATA_W - IN_DATA_W;
    localparam int OUT_DATA_W  = PLAYER_W + SOURCE_W + KIND_W + AMOUNT_W + TIME_W + TOTAL_W;
    localparam int OUT_TDATA_W = ((OUT_DATA_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_DATA_W;

    typedef enum logic [ACTION_W-1:0] {
        ACT_APPEND       = 3'd0,
        ACT_CLEAR        = 3'd1,
        ACT_REMOVE_MATCH = 3'd2,
        ACT_REMOVE_POS   = 3'd3,
        ACT_READ_POS     = 3'd4
    } t_action;

    // one stored record, as held in the ring memory
    typedef struct packed {
        logic        [TIME_W-1:0]   rec_time;
        logic signed [AMOUNT_W-1:0] rec_amount;
        logic        [KIND_W-1:0]   rec_kind;
        logic signed [SOURCE_W-1:0] rec_source;
        logic        [PLAYER_W-1:0] rec_player;
    } t_rec;

    localparam int REC_W = $bits(t_rec);

    typedef struct packed {
        logic        [IN_PAD_W-1:0] pad;
        logic        [POS_W-1:0]    position;
        logic        [TIME_W-1:0]   time_stamp;
        logic signed [AMOUNT_W-1:0] change_amount;
        logic        [KIND_W-1:0]   event_kind;
        logic signed [SOURCE_W-1:0] source_code;
        logic        [PLAYER_W-1:0] player_id;
    } t_in_data;

    typedef struct packed {
        logic        [OUT_PAD_W-1:0] pad;
        logic        [TOTAL_W-1:0]   entry_total;
        logic        [TIME_W-1:0]    rec_time;
        logic signed [AMOUNT_W-1:0]  rec_amount;
        logic        [KIND_W-1:0]    rec_kind;
        logic signed [SOURCE_W-1:0]  rec_source;
        logic        [PLAYER_W-1:0]  rec_player;
    } t_out_data;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic append;
        logic clear;
        logic set_ok;
        logic rd_pos;
        logic cap_rec;
        logic srch_start;
        logic srch_step;
        logic srch_hit;
        logic shift_prime;
        logic shift_step;
        logic remove_end;
        logic load_out;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        t_action act;
        logic    append_ok;
        logic    pos_ok;
        logic    fill_zero;
        logic    match;
        logic    exhausted;
        logic    cmp_zero;
        logic    idx_zero;
        logic    idx_one;
        logic    out_free;
    } t_dp_stat;

endpackage

// ----- design/evhr_ram.sv -----
// generic simple dual port ram with registered read
module evhr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/evhr_ctrl.sv -----
// sequencing state machine for the event history ring
module evhr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  evhr_pkg::t_dp_stat i_stat,
    output evhr_pkg::t_dp_cmd  o_cmd,
    output logic              o_ready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_RD_WAIT,
        S_RM_WAIT,
        S_SEARCH,
        S_SH_PRIME,
        S_SH_RUN,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_accept) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_FINISH;
                case (i_stat.act)
                    evhr_pkg::ACT_APPEND: begin
                        if (i_stat.append_ok) begin
                            o_cmd.append = 1'b1;
                            o_cmd.set_ok = 1'b1;
                        end
                    end
                    evhr_pkg::ACT_CLEAR: begin
                        o_cmd.clear  = 1'b1;
                        o_cmd.set_ok = 1'b1;
                    end
                    evhr_pkg::ACT_READ_POS: begin
                        if (i_stat.pos_ok) begin
                            o_cmd.rd_pos = 1'b1;
                            n_state      = S_RD_WAIT;
                        end
                    end
                    evhr_pkg::ACT_REMOVE_POS: begin
                        if (i_stat.pos_ok) begin
                            o_cmd.rd_pos = 1'b1;
                            n_state      = S_RM_WAIT;
                        end
                    end
                    evhr_pkg::ACT_REMOVE_MATCH: begin
                        if (!i_stat.fill_zero) begin
                            o_cmd.srch_start = 1'b1;
                            n_state          = S_SEARCH;
                        end
                    end
                    default: begin
                        n_state = S_FINISH;
                    end
                endcase
            end
            S_RD_WAIT: begin
                o_cmd.cap_rec = 1'b1;
                o_cmd.set_ok  = 1'b1;
                n_state       = S_FINISH;
            end
            S_RM_WAIT: begin
                o_cmd.cap_rec = 1'b1;
                o_cmd.set_ok  = 1'b1;
                if (i_stat.idx_zero) begin
                    o_cmd.remove_end = 1'b1;
                    n_state          = S_FINISH;
                end else begin
                    n_state = S_SH_PRIME;
                end
            end
            S_SEARCH: begin
                if (i_stat.match) begin
                    o_cmd.cap_rec  = 1'b1;
                    o_cmd.set_ok   = 1'b1;
                    o_cmd.srch_hit = 1'b1;
                    if (i_stat.cmp_zero) begin
                        o_cmd.remove_end = 1'b1;
                        n_state          = S_FINISH;
                    end else begin
                        n_state = S_SH_PRIME;
                    end
                end else if (i_stat.exhausted) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.srch_step = 1'b1;
                end
            end
            S_SH_PRIME: begin
                o_cmd.shift_prime = 1'b1;
                n_state           = S_SH_RUN;
            end
            S_SH_RUN: begin
                o_cmd.shift_step = 1'b1;
                if (i_stat.idx_one) begin
                    o_cmd.remove_end = 1'b1;
                    n_state          = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ready <= (n_state == S_IDLE);
        end
    end

    assign o_ready = r_ready;

endmodule

// ----- design/evhr_dp.sv -----
// datapath of the event history ring: pointers, ring memory, record and output registers
module evhr_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  evhr_pkg::t_dp_cmd                   i_cmd,
    output evhr_pkg::t_dp_stat                  o_stat,
    input  logic [evhr_pkg::IN_TDATA_W-1:0]     i_in_data,
    input  logic [evhr_pkg::ACTION_W-1:0]       i_in_action,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [evhr_pkg::OUT_TDATA_W-1:0]    o_out_data,
    output logic                                o_out_status
);

    localparam int PTR_W = evhr_pkg::PTR_W;
    localparam int CNT_W = evhr_pkg::CNT_W;

    // slot of a position, 0 is the newest record
    function automatic logic [PTR_W-1:0] f_slot(input logic [PTR_W-1:0] head,
                                                 input logic [CNT_W-1:0] pos);
        logic [CNT_W-1:0] t;
        t = CNT_W'(head) - pos - CNT_W'(1);
        return t[PTR_W-1:0];
    endfunction

    evhr_pkg::t_in_data  w_in;
    evhr_pkg::t_rec      w_rd_data;
    evhr_pkg::t_rec      w_wr_data;
    evhr_pkg::t_out_data w_out;

    // latched item
    logic [evhr_pkg::ACTION_W-1:0]        r_act;
    logic [evhr_pkg::PLAYER_W-1:0]        r_player;
    logic signed [evhr_pkg::SOURCE_W-1:0] r_source;
    logic [evhr_pkg::KIND_W-1:0]          r_kind;
    logic signed [evhr_pkg::AMOUNT_W-1:0] r_amount;
    logic [evhr_pkg::TIME_W-1:0]          r_time;
    logic [evhr_pkg::POS_W-1:0]           r_pos;

    // ring control and work counters
    logic [PTR_W-1:0] r_head;
    logic [CNT_W-1:0] r_fill;
    logic [CNT_W-1:0] r_idx;
    logic [CNT_W-1:0] r_cmp_idx;
    logic             r_cmp_vld;

    // result
    evhr_pkg::t_rec              r_rec;
    logic                        r_status;
    logic                        r_out_valid;
    logic [evhr_pkg::OUT_TDATA_W-1:0] r_out_data;
    logic                        r_out_status;

    logic             w_re;
    logic [PTR_W-1:0] w_raddr;
    logic             w_we;
    logic [PTR_W-1:0] w_waddr;
    logic [CNT_W-1:0] w_pos_ext;

    assign w_in      = evhr_pkg::t_in_data'(i_in_data);
    assign w_pos_ext = CNT_W'(r_pos);

    // read address select
    always_comb begin
        w_re    = i_cmd.rd_pos | i_cmd.srch_start | i_cmd.srch_step |
                  i_cmd.shift_prime | i_cmd.shift_step;
        w_raddr = f_slot(r_head, r_idx - CNT_W'(2));
        if (i_cmd.rd_pos) begin
            w_raddr = f_slot(r_head, w_pos_ext);
        end else if (i_cmd.srch_start) begin
            w_raddr = f_slot(r_head, '0);
        end else if (i_cmd.srch_step) begin
            w_raddr = f_slot(r_head, r_idx);
        end else if (i_cmd.shift_prime) begin
            w_raddr = f_slot(r_head, r_idx - CNT_W'(1));
        end
    end

    // write: append at head, or move one record toward the old end
    always_comb begin
        w_we                 = i_cmd.append | i_cmd.shift_step;
        w_waddr              = f_slot(r_head, r_idx);
        w_wr_data            = w_rd_data;
        if (i_cmd.append) begin
            w_waddr              = r_head;
            w_wr_data.rec_time   = r_time;
            w_wr_data.rec_amount = r_amount;
            w_wr_data.rec_kind   = r_kind;
            w_wr_data.rec_source = r_source;
            w_wr_data.rec_player = r_player;
        end
    end

    evhr_ram #(
        .WIDTH (evhr_pkg::REC_W),
        .DEPTH (evhr_pkg::LOG_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wr_data),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rd_data)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_fill      <= '0;
            r_idx       <= '0;
            r_cmp_idx   <= '0;
            r_cmp_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.append) begin
                r_head <= r_head + PTR_W'(1);
                if (r_fill != CNT_W'(evhr_pkg::LOG_DEPTH)) begin
                    r_fill <= r_fill + CNT_W'(1);
                end
            end
            if (i_cmd.clear) begin
                r_head <= '0;
                r_fill <= '0;
            end
            if (i_cmd.remove_end) begin
                r_head <= r_head - PTR_W'(1);
                r_fill <= r_fill - CNT_W'(1);
            end
            if (i_cmd.rd_pos) begin
                r_idx <= w_pos_ext;
            end
            if (i_cmd.srch_start) begin
                r_idx     <= CNT_W'(1);
                r_cmp_idx <= '0;
                r_cmp_vld <= 1'b1;
            end
            if (i_cmd.srch_step) begin
                r_idx     <= r_idx + CNT_W'(1);
                r_cmp_idx <= r_idx;
                r_cmp_vld <= (r_idx < r_fill);
            end
            if (i_cmd.srch_hit) begin
                r_idx <= r_cmp_idx;
            end
            if (i_cmd.shift_step) begin
                r_idx <= r_idx - CNT_W'(1);
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_act    <= i_in_action;
            r_player <= w_in.player_id;
            r_source <= w_in.source_code;
            r_kind   <= w_in.event_kind;
            r_amount <= w_in.change_amount;
            r_time   <= w_in.time_stamp;
            r_pos    <= w_in.position;
            r_rec    <= '0;
            r_status <= 1'b1;
        end else begin
            if (i_cmd.set_ok) begin
                r_status <= 1'b0;
            end
            if (i_cmd.cap_rec) begin
                r_rec <= w_rd_data;
            end
        end
        if (i_cmd.load_out) begin
            r_out_data   <= w_out;
            r_out_status <= r_status;
        end
    end

    always_comb begin
        w_out             = '0;
        w_out.entry_total = r_fill;
        w_out.rec_time    = r_rec.rec_time;
        w_out.rec_amount  = r_rec.rec_amount;
        w_out.rec_kind    = r_rec.rec_kind;
        w_out.rec_source  = r_rec.rec_source;
        w_out.rec_player  = r_rec.rec_player;
    end

    always_comb begin
        o_stat           = '0;
        o_stat.act       = evhr_pkg::t_action'(r_act);
        o_stat.append_ok = (r_amount != '0) && (int'(r_player) < evhr_pkg::PLAYER_COUNT);
        o_stat.pos_ok    = (w_pos_ext < r_fill);
        o_stat.fill_zero = (r_fill == '0);
        o_stat.match     = r_cmp_vld && (w_rd_data.rec_player == r_player) &&
                           (w_rd_data.rec_kind == r_kind);
        o_stat.exhausted = !r_cmp_vld;
        o_stat.cmp_zero  = (r_cmp_idx == '0);
        o_stat.idx_zero  = (r_idx == '0);
        o_stat.idx_one   = (r_idx == CNT_W'(1));
        o_stat.out_free  = !r_out_valid || i_out_ready;
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_data   = r_out_data;
    assign o_out_status = r_out_status;

endmodule

// ----- design/event_history_ring_with_delete_top.sv -----
// top level of the event history ring with compacting delete
// a remove closes the gap by moving each newer record one slot toward the old end,
// with one ring memory read and write per moved entry; remove newest matching first
// searches from the newest record toward the oldest
// one item at a time; the next item is taken while a result waits in the output register
// reset: synchronous active low, clears head pointer, count and handshake state;
// the ring memory is not cleared and holds nothing valid until written
module event_history_ring_with_delete_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input item stream
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // tdata from bit 0: player_id, source_code, event_kind, change_amount,
    // time_stamp, position, zero pad
    input  logic [evhr_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    // tuser: action
    input  logic [evhr_pkg::ACTION_W-1:0]     i_s_axis_tuser,
    // result item stream
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // tdata from bit 0: rec_player, rec_source, rec_kind, rec_amount,
    // rec_time, entry_total, zero pad
    output logic [evhr_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,
    // tuser: status
    output logic                              o_m_axis_tuser
);

    evhr_pkg::t_dp_cmd  w_cmd;
    evhr_pkg::t_dp_stat w_stat;
    logic               w_ready;
    logic               w_accept;

    // item accepted on a valid and ready edge
    assign w_accept        = i_s_axis_tvalid && w_ready;
    assign o_s_axis_tready = w_ready;

    // sequencer: decodes the action and walks search and shift
    evhr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_stat   (w_stat),
        .o_cmd    (w_cmd),
        .o_ready  (w_ready)
    );

    // datapath: ring memory, head and count, record capture and output register
    evhr_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_in_data    (i_s_axis_tdata),
        .i_in_action  (i_s_axis_tuser),
        .i_out_ready  (i_m_axis_tready),
        .o_out_valid  (o_m_axis_tvalid),
        .o_out_data   (o_m_axis_tdata),
        .o_out_status (o_m_axis_tuser)
    );

endmodule
